FILE: hw/rtl/zero_run_literal_encoder_macros.svh
// Assertion macros for the zero-run / literal encoder.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ZERO_RUN_LITERAL_ENCODER_MACROS_SVH
`define ZERO_RUN_LITERAL_ENCODER_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ZRLE_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante
`define ZRLE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/zrle_pkg.sv
// Shared types and constants of the zero-run / literal encoder.
// No dependencies; used by the front end, queue, back end and top level.
package zrle_pkg;

	// Token tag as sent on the wire
	typedef enum logic {
		TOK_RUN = 1'b0,
		TOK_LIT = 1'b1
	} tok_kind_t;

	localparam int HOLD_DEPTH = 2;   // source bytes kept for a short open run
	localparam int LIT_BITS   = 8;   // literal payload bits
	localparam int VAL_W      = 16;  // token value width
	localparam int TOT_W      = 16;  // bit total width
	localparam int MAX_TOK    = 3;   // tokens one item can cause

	typedef struct packed {
		tok_kind_t        kind;
		logic [VAL_W-1:0] value;
	} tok_t;

	// One queued command: up to three tokens, in slot order
	typedef struct packed {
		logic [1:0]             count;
		tok_t [MAX_TOK-1:0]     tok;
		logic                   eom;
	} cmd_t;

endpackage

FILE: hw/rtl/zrle_fifo.sv
// Command queue between the encoder front end and back end.
// Depends on zrle_pkg for the command type.
module zrle_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  zrle_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output zrle_pkg::cmd_t head
);
	import zrle_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

FILE: hw/rtl/zrle_front.sv
// Front end: tracks the open zero run and turns accepted items that close tokens
// into token commands for the queue. Depends on zrle_pkg.
module zrle_front #(
	parameter int RUN_FIELD_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     mask_byte,
	input  logic [7:0]     source_byte,
	input  logic           end_of_mask,
	output logic           push,
	output zrle_pkg::cmd_t cmd
);
	import zrle_pkg::*;

	localparam int RW     = RUN_FIELD_BITS;
	localparam int THRESH = RUN_FIELD_BITS / 8 + 1;

	logic [RW-1:0] pending_q;
	logic          committed_q;
	logic [7:0]    held_q [HOLD_DEPTH];

	logic [RW-1:0] pend;
	logic          hold;
	logic          hold_idx;
	logic [RW-1:0] pending_n;
	logic          committed_n;
	logic [7:0]    held_n [HOLD_DEPTH];
	logic          do_flush;
	logic          do_lit;
	logic          do_cap;
	logic [RW-1:0] fl_len;
	logic          fl_comm;
	logic [1:0]    n;

	assign pend     = pending_q + RW'(1);
	assign hold     = !committed_q && (pend < RW'(THRESH)) && (pend <= RW'(HOLD_DEPTH));
	assign hold_idx = pend[0] ? 1'b0 : 1'b1;

	// Next run state and what this item closes
	always_comb begin
		held_n      = held_q;
		pending_n   = pending_q;
		committed_n = committed_q;
		fl_len      = pending_q;
		fl_comm     = committed_q;
		do_flush    = 1'b0;
		do_lit      = 1'b0;
		do_cap      = 1'b0;
		if (mask_byte == 8'd0) begin
			if (hold)
				held_n[hold_idx] = source_byte;
			else
				committed_n = 1'b1;
			pending_n = pend;
			if (pend == '1) begin
				do_cap      = 1'b1;
				pending_n   = '0;
				committed_n = 1'b0;
			end else if (end_of_mask) begin
				do_flush    = 1'b1;
				fl_len      = pend;
				fl_comm     = committed_n;
				pending_n   = '0;
				committed_n = 1'b0;
			end
		end else begin
			do_flush    = 1'b1;
			do_lit      = 1'b1;
			pending_n   = '0;
			committed_n = 1'b0;
		end
	end

	// Lay the tokens into command slots in output order
	always_comb begin
		cmd.tok = '0;
		cmd.eom = end_of_mask;
		n       = 2'd0;
		if (do_cap) begin
			cmd.tok[0] = '{kind: TOK_RUN, value: VAL_W'(pend)};
			n          = 2'd1;
		end
		if (do_flush && fl_len != '0) begin
			if (fl_comm) begin
				cmd.tok[0] = '{kind: TOK_RUN, value: VAL_W'(fl_len)};
				n          = 2'd1;
			end else begin
				cmd.tok[0] = '{kind: TOK_LIT, value: VAL_W'(held_n[0])};
				n          = 2'd1;
				if (fl_len != RW'(1)) begin
					cmd.tok[1] = '{kind: TOK_LIT, value: VAL_W'(held_n[1])};
					n          = 2'd2;
				end
			end
		end
		if (do_lit) begin
			case (n)
				2'd0:    cmd.tok[0] = '{kind: TOK_LIT, value: VAL_W'(source_byte)};
				2'd1:    cmd.tok[1] = '{kind: TOK_LIT, value: VAL_W'(source_byte)};
				default: cmd.tok[2] = '{kind: TOK_LIT, value: VAL_W'(source_byte)};
			endcase
			n = n + 2'd1;
		end
		cmd.count = n;
	end

	assign push = accept && (n != 2'd0);

	// Hold the run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			committed_q <= 1'b0;
		end else if (accept) begin
			pending_q   <= pending_n;
			committed_q <= committed_n;
		end
	end

	// Keep source bytes of a short run
	always_ff @(posedge clk) begin
		if (accept)
			held_q <= held_n;
	end

endmodule

FILE: hw/rtl/zrle_back.sv
// Back end: walks the head command's token slots, one per cycle unless stalled,
// keeps the saturating bit total and drives the output register. Uses zrle_pkg.
module zrle_back #(
	parameter int RUN_FIELD_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  zrle_pkg::cmd_t             head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output zrle_pkg::tok_kind_t        out_kind,
	output logic [zrle_pkg::VAL_W-1:0] out_value,
	output logic [zrle_pkg::TOT_W-1:0] out_total,
	output logic                       out_last
);
	import zrle_pkg::*;

	localparam int RUN_TOK_BITS = 1 + RUN_FIELD_BITS;
	localparam int LIT_TOK_BITS = 1 + LIT_BITS;

	logic             out_valid_q;
	tok_kind_t        kind_q;
	logic [VAL_W-1:0] value_q;
	logic [TOT_W-1:0] total_q;
	logic             last_q;
	logic [1:0]       idx_q;
	logic [TOT_W-1:0] bit_cnt_q;

	tok_t             cur;
	logic             load;
	logic             last_slot;
	logic [4:0]       tok_bits;
	logic [TOT_W:0]   sum;
	logic [TOT_W-1:0] sat;

	assign cur       = head.tok[idx_q];
	assign load      = head_valid && (!out_valid_q || out_ready);
	assign last_slot = (idx_q == head.count - 2'd1);
	assign pop       = load && last_slot;

	// Add this token's size to the mask total, clamp at the top
	assign tok_bits = (cur.kind == TOK_RUN) ? 5'(RUN_TOK_BITS) : 5'(LIT_TOK_BITS);
	assign sum      = {1'b0, bit_cnt_q} + (TOT_W + 1)'(tok_bits);
	assign sat      = sum[TOT_W] ? '1 : sum[TOT_W-1:0];

	// Advance slot index, bit total and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			bit_cnt_q   <= '0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (load) begin
				idx_q     <= last_slot ? 2'd0 : idx_q + 2'd1;
				bit_cnt_q <= (last_slot && head.eom) ? '0 : sat;
			end
		end
	end

	// Load the token payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= cur.kind;
			value_q <= cur.value;
			total_q <= sat;
			last_q  <= last_slot && head.eom;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_value = value_q;
	assign out_total = total_q;
	assign out_last  = last_q;

endmodule

FILE: hw/rtl/zero_run_literal_encoder.sv
// Zero-run / literal token encoder, top level; uses zrle_pkg, the front end,
// the command queue, the back end and the assertion macro header.
// An accepted item's tokens pass through the command queue and the output register.
// Throughput: one item per cycle while the queue is not full; the back end sends one
// token per cycle while the output is not stalled; the queue holds QUEUE_DEPTH commands.
// Reset clears the open run, the bit total, the queue and the output valid.
`include "zero_run_literal_encoder_macros.svh"

module zero_run_literal_encoder #(
	parameter int RUN_FIELD_BITS = 8,
	parameter int QUEUE_DEPTH    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [7:0] mask_byte, [15:8] source_byte
	input  logic        s_axis_tlast,   // end_of_mask
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [15:0] token_value, [31:16] total_bits
	output logic [0:0]  m_axis_tuser,   // [0] token_kind
	output logic        m_axis_tlast    // last_token
);
	import zrle_pkg::*;

	localparam logic [VAL_W-1:0] RUN_CAP = VAL_W'((1 << RUN_FIELD_BITS) - 1);

	logic             accept;
	logic             push;
	cmd_t             push_cmd;
	logic             fifo_full;
	logic             head_valid;
	cmd_t             head;
	logic             pop;
	tok_kind_t        out_kind;
	logic [VAL_W-1:0] out_value;
	logic [TOT_W-1:0] out_total;

	assign s_axis_tready = !fifo_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	zrle_front #(
		.RUN_FIELD_BITS(RUN_FIELD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.mask_byte  (s_axis_tdata[7:0]),
		.source_byte(s_axis_tdata[15:8]),
		.end_of_mask(s_axis_tlast),
		.push       (push),
		.cmd        (push_cmd)
	);

	zrle_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (fifo_full),
		.head_valid(head_valid),
		.head      (head)
	);

	zrle_back #(
		.RUN_FIELD_BITS(RUN_FIELD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (out_kind),
		.out_value (out_value),
		.out_total (out_total),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {out_total, out_value};
	assign m_axis_tuser = out_kind;

	// A queued command always carries at least one token
	`ZRLE_ASSERT_NOW(a_head_nonempty, head_valid, head.count != 2'd0, "empty command queued")
	// Pop only from a filled queue
	`ZRLE_ASSERT_NOW(a_pop_has_data, pop, head_valid, "pop from empty queue")
	// A run token never exceeds the run cap and is never empty
	`ZRLE_ASSERT_NOW(a_run_range, m_axis_tvalid && (m_axis_tuser[0] == TOK_RUN),
		(m_axis_tdata[15:0] != 16'd0) && (m_axis_tdata[15:0] <= RUN_CAP),
		"run token length out of range")
	// Within a mask the bit total never decreases from one token to the next
	`ZRLE_ASSERT_NEXT(a_total_grows, m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		!m_axis_tvalid || (m_axis_tdata[31:16] >= $past(m_axis_tdata[31:16])),
		"bit total went down inside a mask")

endmodule
